// ===== hdl/ltc_pkg.sv =====
// Shared types, character codes, type codes and scan helpers for the
// literal token type classifier. No dependencies.
`timescale 1ns / 1ps

package ltc_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] code_t;

    // scan phases of the token state machine
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_INT    = 3'd1,
        PH_FRAC   = 3'd2,
        PH_QUOTE  = 3'd3,
        PH_ESC    = 3'd4,
        PH_AFTERQ = 3'd5,
        PH_TAG    = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    // result type codes
    localparam code_t TC_INVALID = 4'd0;
    localparam code_t TC_I8      = 4'd1;
    localparam code_t TC_U8      = 4'd2;
    localparam code_t TC_I16     = 4'd3;
    localparam code_t TC_U16     = 4'd4;
    localparam code_t TC_I32     = 4'd5;
    localparam code_t TC_U32     = 4'd6;
    localparam code_t TC_I64     = 4'd7;
    localparam code_t TC_U64     = 4'd8;
    localparam code_t TC_OBJID   = 4'd9;
    localparam code_t TC_FLOAT   = 4'd10;
    localparam code_t TC_DOUBLE  = 4'd11;
    localparam code_t TC_STRING  = 4'd12;
    localparam code_t TC_ZSTRING = 4'd13;
    localparam code_t TC_BINARY  = 4'd14;

    // configuration register indexes
    localparam logic [1:0] REG_TAG_OFFSET = 2'd0;
    localparam logic [1:0] REG_OBJECT_TAG = 2'd1;
    localparam logic [1:0] REG_BINARY_TAG = 2'd2;

    // register reset values
    localparam byte_t TAG_OFFSET_RST = 8'd1;
    localparam byte_t OBJECT_TAG_RST = 8'd0;
    localparam byte_t BINARY_TAG_RST = 8'd0;

    // ascii codes
    localparam byte_t CH_NUL    = 8'h00;
    localparam byte_t CH_QUOTE  = 8'h22;
    localparam byte_t CH_DOT    = 8'h2E;
    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_UP_B   = 8'h42;
    localparam byte_t CH_UP_H   = 8'h48;
    localparam byte_t CH_UP_I   = 8'h49;
    localparam byte_t CH_UP_L   = 8'h4C;
    localparam byte_t CH_UP_Q   = 8'h51;
    localparam byte_t CH_UP_S   = 8'h53;
    localparam byte_t CH_LO_B   = 8'h62;
    localparam byte_t CH_LO_D   = 8'h64;
    localparam byte_t CH_LO_F   = 8'h66;
    localparam byte_t CH_LO_H   = 8'h68;
    localparam byte_t CH_LO_I   = 8'h69;
    localparam byte_t CH_LO_L   = 8'h6C;
    localparam byte_t CH_LO_Q   = 8'h71;

    // configuration registers as seen by the scan logic
    typedef struct packed {
        byte_t tag_offset;
        byte_t object_tag;
        byte_t binary_tag;
    } cfg_t;

    // one input beat held in the input register
    typedef struct packed {
        byte_t data;
        logic  last;
    } beat_t;

    // scan state carried from byte to byte
    typedef struct packed {
        phase_t phase;
        code_t  code;
    } scan_t;

    function automatic logic is_digit(input byte_t b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input byte_t b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_punct(input byte_t b);
        return (b >= 8'h21) && (b <= 8'h7E) && !is_alpha(b) && !is_digit(b);
    endfunction

    // integer width suffix
    function automatic code_t int_suffix(input byte_t b);
        code_t c;
        case (b) inside
            CH_LO_B:          c = TC_I8;
            CH_UP_B:          c = TC_U8;
            CH_LO_H:          c = TC_I16;
            CH_UP_H:          c = TC_U16;
            CH_LO_I, CH_LO_L: c = TC_I32;
            CH_UP_I, CH_UP_L: c = TC_U32;
            CH_LO_Q:          c = TC_I64;
            CH_UP_Q:          c = TC_U64;
            default:          c = TC_STRING;
        endcase
        return c;
    endfunction

    // tag byte match, object id wins when both tags are equal
    function automatic code_t tag_code(input byte_t b, input cfg_t cfg);
        code_t c;
        if (b == cfg.object_tag)
            c = TC_OBJID;
        else if (b == cfg.binary_tag)
            c = TC_BINARY;
        else
            c = TC_INVALID;
        return c;
    endfunction

    // one step of the scan for one byte
    function automatic scan_t take_byte(input scan_t s, input byte_t b,
                                        input byte_t pos, input cfg_t cfg);
        scan_t n;
        n = s;
        unique case (s.phase)
            PH_START:
            begin
                if (is_digit(b))
                    n.phase = PH_INT;
                else if (b == CH_QUOTE)
                begin
                    n.code  = TC_STRING;
                    n.phase = PH_QUOTE;
                end
                else if (is_alpha(b) || is_punct(b) || (b == CH_NUL))
                begin
                    n.code  = TC_STRING;
                    n.phase = PH_DONE;
                end
                else if (cfg.tag_offset == 8'd0)
                begin
                    n.code  = tag_code(b, cfg);
                    n.phase = PH_DONE;
                end
                else
                    n.phase = PH_TAG;
            end
            PH_INT:
            begin
                if (is_digit(b))
                    n = s;
                else if (b == CH_NUL)
                begin
                    n.code  = TC_I32;
                    n.phase = PH_DONE;
                end
                else if (b == CH_DOT)
                    n.phase = PH_FRAC;
                else
                begin
                    n.code  = int_suffix(b);
                    n.phase = PH_DONE;
                end
            end
            PH_FRAC:
            begin
                if (!is_digit(b))
                begin
                    if ((b == CH_NUL) || (b == CH_LO_F))
                        n.code = TC_FLOAT;
                    else if (b == CH_LO_D)
                        n.code = TC_DOUBLE;
                    else
                        n.code = TC_STRING;
                    n.phase = PH_DONE;
                end
            end
            PH_QUOTE:
            begin
                if (b == CH_NUL)
                begin
                    n.code  = TC_STRING;
                    n.phase = PH_DONE;
                end
                else if (b == CH_QUOTE)
                    n.phase = PH_AFTERQ;
                else if (b == CH_BSLASH)
                    n.phase = PH_ESC;
            end
            PH_ESC:
            begin
                // terminator right after a backslash ends the string
                if (b == CH_NUL)
                begin
                    n.code  = TC_STRING;
                    n.phase = PH_DONE;
                end
                else
                    n.phase = PH_QUOTE;
            end
            PH_AFTERQ:
            begin
                n.code  = (b == CH_UP_S) ? TC_ZSTRING : TC_STRING;
                n.phase = PH_DONE;
            end
            PH_TAG:
            begin
                if (pos == cfg.tag_offset)
                begin
                    n.code  = tag_code(b, cfg);
                    n.phase = PH_DONE;
                end
            end
            default:
            begin
                n = s;
            end
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/ltc_cfg_regs.sv =====
// Configuration register file of the token classifier, APB-style access.
// Depends on ltc_pkg.
`timescale 1ns / 1ps

module ltc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output ltc_pkg::cfg_t cfg
);
    import ltc_pkg::*;

    byte_t      tag_offset_reg;
    byte_t      object_tag_reg;
    byte_t      binary_tag_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // register writes, index three is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_offset_reg <= TAG_OFFSET_RST;
            object_tag_reg <= OBJECT_TAG_RST;
            binary_tag_reg <= BINARY_TAG_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TAG_OFFSET: tag_offset_reg <= pwdata[7:0];
                REG_OBJECT_TAG: object_tag_reg <= pwdata[7:0];
                REG_BINARY_TAG: binary_tag_reg <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_TAG_OFFSET: prdata = {24'd0, tag_offset_reg};
            REG_OBJECT_TAG: prdata = {24'd0, object_tag_reg};
            REG_BINARY_TAG: prdata = {24'd0, binary_tag_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.tag_offset = tag_offset_reg;
    assign cfg.object_tag = object_tag_reg;
    assign cfg.binary_tag = binary_tag_reg;

endmodule

// ===== hdl/ltc_in_stage.sv =====
// Input register of the token classifier: holds one accepted byte beat.
// Depends on ltc_pkg.
`timescale 1ns / 1ps

module ltc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic           s_tlast,
    input  logic           advance,
    output logic           beat_valid,
    output ltc_pkg::beat_t beat
);
    import ltc_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    beat_t beat_reg;
    logic  accept;

    // register is free when empty or when its beat moves on this cycle
    assign s_tready = !vld_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (accept)
            vld_next = 1'b1;
        else if (advance)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg.data <= s_tdata;
            beat_reg.last <= s_tlast;
        end
    end

    assign beat_valid = vld_reg;
    assign beat       = beat_reg;

endmodule

// ===== hdl/ltc_core.sv =====
// Scan state machine of the token classifier: one byte per cycle, but a last
// byte waits for a free output register; result on the last byte. Depends on ltc_pkg.
`timescale 1ns / 1ps

module ltc_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            beat_valid,
    input  ltc_pkg::beat_t  beat,
    input  ltc_pkg::cfg_t   cfg,
    input  logic            out_free,
    output logic            advance,
    output logic            res_valid,
    output ltc_pkg::code_t  res_code
);
    import ltc_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    code_t  code_reg;
    code_t  code_next;
    byte_t  pos_reg;
    byte_t  pos_next;
    scan_t  cur;
    scan_t  step;
    scan_t  fin;

    // a last beat needs room in the output register, others never stall
    assign advance   = beat_valid && (!beat.last || out_free);
    assign res_valid = advance && beat.last;

    assign cur.phase = phase_reg;
    assign cur.code  = code_reg;

    // scan the byte, then close an undecided token as if a zero byte came
    always_comb
    begin
        step = take_byte(cur, beat.data, pos_reg, cfg);
        fin  = step;
        if (step.phase == PH_TAG)
        begin
            fin.code  = tag_code(CH_NUL, cfg);
            fin.phase = PH_DONE;
        end
        else if (step.phase != PH_DONE)
            fin = take_byte(step, CH_NUL, pos_reg, cfg);
    end

    assign res_code = fin.code;

    // next state, back to start of token after the last byte
    always_comb
    begin
        phase_next = phase_reg;
        code_next  = code_reg;
        pos_next   = pos_reg;
        if (advance)
        begin
            if (beat.last)
            begin
                phase_next = PH_START;
                code_next  = TC_INVALID;
                pos_next   = 8'd0;
            end
            else
            begin
                phase_next = step.phase;
                code_next  = step.code;
                pos_next   = (pos_reg == 8'hFF) ? pos_reg : pos_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            code_reg  <= TC_INVALID;
            pos_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// ===== hdl/ltc_out_stage.sv =====
// Output register of the token classifier: holds one type code beat.
// Depends on ltc_pkg.
`timescale 1ns / 1ps

module ltc_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_valid,
    input  ltc_pkg::code_t res_code,
    output logic           out_free,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata
);
    import ltc_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    code_t code_reg;

    assign out_free = !vld_reg || m_tready;

    always_comb
    begin
        if (res_valid)
            vld_next = 1'b1;
        else if (m_tready)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
            code_reg <= res_code;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {4'd0, code_reg};

endmodule

// ===== hdl/literal_token_type_classifier_top.sv =====
// Literal token type classifier: byte stream in, one type code per token out.
// Channels: slave stream of token bytes, master stream of type codes, and an
// APB-style port for three 8-bit registers (tag_offset at 0x0, object_tag at
// 0x4, binary_tag at 0x8). Writes land on the access cycle; pready is tied high.
// Each byte beat is held in the input register and scanned by the phase
// machine, and a token's last beat leaves its code in the output register:
// the code passes the input register, then the output register, to m_tvalid.
// Throughput is one byte per cycle unless a last byte waits (see below); the
// output register lets the next token's bytes stream in while a code waits.
// Bytes that are not last never wait on the receiver. A last byte waits in
// the input register while the output register is full and m_tready is low,
// and s_tready then drops until the code is taken.
// Reset clears the valid flags of both beat registers and the scan state, and sets
// the registers to their defaults (tag_offset 1, both tags 0). Depends on ltc_pkg and the ltc_ modules.
`timescale 1ns / 1ps

module literal_token_type_classifier_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_in
    input  logic        s_tlast,    // token_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [3:0] type_code, [7:4] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ltc_pkg::*;

    cfg_t  cfg;
    beat_t beat;
    logic  beat_valid;
    logic  advance;
    logic  out_free;
    logic  res_valid;
    code_t res_code;

    assign pready = 1'b1;

    ltc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ltc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    ltc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat       (beat),
        .cfg        (cfg),
        .out_free   (out_free),
        .advance    (advance),
        .res_valid  (res_valid),
        .res_code   (res_code)
    );

    ltc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_code  (res_code),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== hdl/ltc_checker.sv =====
// Port-level checks for the token classifier, bound to the top level.
// Depends on ltc_pkg.
`timescale 1ns / 1ps

module ltc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    import ltc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a ready receiver never backs up the byte stream
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled with receiver ready");

    // codes stay within the defined set
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:4] == 4'd0) && (m_tdata[3:0] != 4'hF))
        else $error("undefined type code");

    // a written register reads back its low byte
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[3:2] != 2'd3)
        |=> (!psel || pwrite || (paddr != $past(paddr))
             || (prdata == {24'd0, $past(pwdata[7:0])})))
        else $error("register readback mismatch");

endmodule

bind literal_token_type_classifier_top ltc_checker u_ltc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

// ===== tb/tb_literal_token_type_classifier_top.sv =====
// Self-checking testbench for the literal token type classifier: streams token
// bytes in, predicts each type code and checks every output beat and register.
// Depends on ltc_pkg and literal_token_type_classifier_top.
`timescale 1ns / 1ps

module tb_literal_token_type_classifier_top;

    import ltc_pkg::*;

    localparam int         CYCLE_LIMIT = 500000;
    localparam int         PHASE_BEATS = 125;
    localparam int         NUM_PHASES  = 9;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    localparam byte_t INT_SUFFIX [10] = '{CH_LO_B, CH_UP_B, CH_LO_H, CH_UP_H, CH_LO_I,
                                          CH_LO_L, CH_UP_I, CH_UP_L, CH_LO_Q, CH_UP_Q};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] byte_in
    logic        s_tlast  = 1'b0;   // token_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [3:0] type_code, [7:4] zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'h0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // token bytes waiting for the driver and type codes waiting for the block
    beat_t pend_q[$];
    code_t code_q[$];
    byte_t tok_bytes[$];

    int beats_left   = 0;
    int total_pushed = 0;
    int errors       = 0;
    int cycle_cnt    = 0;
    int send_idle    = 0;
    int recv_idle    = 0;

    // register shadow
    byte_t cfg_tag_off = TAG_OFFSET_RST;
    byte_t cfg_obj_tag = OBJECT_TAG_RST;
    byte_t cfg_bin_tag = BINARY_TAG_RST;

    // classifier state of the predictor
    phase_t tok_phase = PH_START;
    code_t  tok_code  = TC_INVALID;
    bit     tok_done  = 1'b0;
    byte_t  tok_pos   = 8'h00;

    literal_token_type_classifier_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit chr_digit(input byte_t b);
        return b inside {[8'h30:8'h39]};
    endfunction

    // bytes that send a token to the tag match: control, space, DEL and high bytes
    function automatic bit is_tag_lead(input byte_t b);
        return (b != CH_NUL) && ((b <= 8'h20) || (b >= 8'h7F));
    endfunction

    function automatic code_t tag_result(input byte_t b);
        if (b == cfg_obj_tag)
            return TC_OBJID;
        if (b == cfg_bin_tag)
            return TC_BINARY;
        return TC_INVALID;
    endfunction

    function automatic code_t suffix_code(input byte_t b);
        case (b)
            CH_LO_B:          return TC_I8;
            CH_UP_B:          return TC_U8;
            CH_LO_H:          return TC_I16;
            CH_UP_H:          return TC_U16;
            CH_LO_I, CH_LO_L: return TC_I32;
            CH_UP_I, CH_UP_L: return TC_U32;
            CH_LO_Q:          return TC_I64;
            CH_UP_Q:          return TC_U64;
            default:          return TC_STRING;
        endcase
    endfunction

    function automatic void settle(input code_t c);
        tok_code  = c;
        tok_done  = 1'b1;
        tok_phase = PH_DONE;
    endfunction

    function automatic void advance_scan(input byte_t b);
        case (tok_phase)
            PH_START:
            begin
                if (chr_digit(b))
                    tok_phase = PH_INT;
                else if (b == CH_QUOTE)
                begin
                    tok_code  = TC_STRING;
                    tok_phase = PH_QUOTE;
                end
                else if (!is_tag_lead(b))
                    settle(TC_STRING);
                else if (cfg_tag_off == 8'h00)
                    settle(tag_result(b));
                else
                    tok_phase = PH_TAG;
            end
            PH_INT:
            begin
                if (b == CH_NUL)
                    settle(TC_I32);
                else if (b == CH_DOT)
                    tok_phase = PH_FRAC;
                else if (!chr_digit(b))
                    settle(suffix_code(b));
            end
            PH_FRAC:
            begin
                if (b == CH_NUL || b == CH_LO_F)
                    settle(TC_FLOAT);
                else if (b == CH_LO_D)
                    settle(TC_DOUBLE);
                else if (!chr_digit(b))
                    settle(TC_STRING);
            end
            PH_QUOTE:
            begin
                if (b == CH_NUL)
                    settle(TC_STRING);
                else if (b == CH_QUOTE)
                    tok_phase = PH_AFTERQ;
                else if (b == CH_BSLASH)
                    tok_phase = PH_ESC;
            end
            PH_ESC:
            begin
                // terminator right after a backslash closes the string
                if (b == CH_NUL)
                    settle(TC_STRING);
                else
                    tok_phase = PH_QUOTE;
            end
            PH_AFTERQ:
                settle((b == CH_UP_S) ? TC_ZSTRING : TC_STRING);
            PH_TAG:
            begin
                if (tok_pos == cfg_tag_off)
                    settle(tag_result(b));
            end
            default:
            begin
            end
        endcase
    endfunction

    // one accepted beat; returns 1 with the type code on the last beat of a token
    function automatic bit step_token(input byte_t b, input logic last, output code_t code);
        code = TC_INVALID;
        if (!tok_done)
            advance_scan(b);
        if (tok_pos != 8'hFF)
            tok_pos++;
        if (!last)
            return 1'b0;
        // token cut short: behave as if the terminator came now
        if (!tok_done)
        begin
            if (tok_phase == PH_TAG)
                settle(tag_result(CH_NUL));
            else
                advance_scan(CH_NUL);
        end
        code      = tok_code;
        tok_phase = PH_START;
        tok_code  = TC_INVALID;
        tok_done  = 1'b0;
        tok_pos   = 8'h00;
        return 1'b1;
    endfunction

    // random byte in a range
    function automatic byte_t rnd_byte(input int unsigned lo, input int unsigned hi);
        return byte_t'($urandom_range(lo, hi));
    endfunction

    // ------------------------------------------------------- driver and monitor

    // input driver, fed from the pending byte queue
    always @(posedge clk)
    begin
        beat_t nb;
        if (!s_tvalid || s_tready)
        begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                nb = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nb.data;
                s_tlast  <= nb.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output backpressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // predict on every accepted input beat, check every accepted output beat
    always @(posedge clk)
    begin
        code_t c;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (step_token(s_tdata, s_tlast, c))
                    code_q.push_back(c);
                beats_left--;
            end
            if (m_tvalid && m_tready)
            begin
                if (code_q.size() == 0)
                begin
                    $display("%0t: unexpected type code beat, expected none actual %0d",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    c = code_q.pop_front();
                    if (m_tdata !== {4'h0, c})
                    begin
                        $display("%0t: type code mismatch, expected %0d actual %0d",
                                 $time, {4'h0, c}, m_tdata);
                        errors++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    // move the assembled token to the pending queue, last flag on its final byte
    task automatic flush_token();
        foreach (tok_bytes[i])
            pend_q.push_back('{data: tok_bytes[i], last: (i == tok_bytes.size() - 1)});
        beats_left   += tok_bytes.size();
        total_pushed += tok_bytes.size();
        tok_bytes.delete();
    endtask

    task automatic queue_text(input string s, input bit add_nul);
        for (int i = 0; i < s.len(); i++)
            tok_bytes.push_back(byte_t'(s[i]));
        if (add_nul)
            tok_bytes.push_back(CH_NUL);
        flush_token();
    endtask

    // register write over apb, then read back unless the index is unused
    task automatic reg_write(input logic [1:0] idx, input byte_t v);
        logic [31:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TAG_OFFSET: cfg_tag_off = v;
            REG_OBJECT_TAG: cfg_obj_tag = v;
            REG_BINARY_TAG: cfg_bin_tag = v;
            default:
            begin
            end
        endcase
        if (idx != REG_UNUSED)
        begin
            @(posedge clk);
            psel    <= 1'b1;
            paddr   <= {idx, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            got = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            if (got !== {24'h0, v})
            begin
                $display("%0t: register %0d readback mismatch, expected %0h actual %0h",
                         $time, idx, {24'h0, v}, got);
                errors++;
            end
        end
    endtask

    // drain: every byte taken, every code seen, then an idle tail
    task automatic wait_idle();
        while (beats_left != 0 || code_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // one random token, mostly well formed, some noise and some cut short
    task automatic queue_random_token();
        int    cls;
        int    r;
        int    keep;
        byte_t lead;
        byte_t pick;
        r = $urandom_range(99);
        cls = (r < 25) ? 0 : (r < 45) ? 1 : (r < 58) ? 2 : (r < 82) ? 3 : 4;
        case (cls)
            0:
            begin
                // integer or decimal
                repeat ($urandom_range(1, 5)) tok_bytes.push_back(rnd_byte(8'h30, 8'h39));
                r = $urandom_range(9);
                if (r < 4)
                begin
                    if ($urandom_range(9) == 0)
                        tok_bytes.push_back(rnd_byte(1, 255));
                    else
                        tok_bytes.push_back(INT_SUFFIX[$urandom_range(9)]);
                    // trailing bytes after the decision are ignored
                    repeat ($urandom_range(0, 3)) tok_bytes.push_back(rnd_byte(0, 255));
                end
                else if (r < 9 && r != 4)
                begin
                    tok_bytes.push_back(CH_DOT);
                    repeat ($urandom_range(0, 4)) tok_bytes.push_back(rnd_byte(8'h30, 8'h39));
                    case ($urandom_range(3))
                        0:       tok_bytes.push_back(CH_LO_F);
                        1:       tok_bytes.push_back(CH_LO_D);
                        2:       ;
                        default: tok_bytes.push_back(rnd_byte(1, 255));
                    endcase
                end
                else if (r == 9)
                    tok_bytes.push_back(rnd_byte(1, 255));
                tok_bytes.push_back(CH_NUL);
            end
            1:
            begin
                // quoted string with escapes
                tok_bytes.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 8))
                begin
                    if ($urandom_range(19) < 3)
                    begin
                        tok_bytes.push_back(CH_BSLASH);
                        if ($urandom_range(9) == 0)
                            tok_bytes.push_back(CH_NUL);
                        else
                            tok_bytes.push_back(rnd_byte(1, 255));
                    end
                    else
                        tok_bytes.push_back(rnd_byte(8'h20, 8'h7E));
                end
                if ($urandom_range(9) < 8)
                begin
                    tok_bytes.push_back(CH_QUOTE);
                    if ($urandom_range(1))
                        tok_bytes.push_back(CH_UP_S);
                    else
                        tok_bytes.push_back(rnd_byte(1, 255));
                end
                tok_bytes.push_back(CH_NUL);
            end
            2:
            begin
                // bare word: letter, punctuation or lone terminator
                r = $urandom_range(9);
                if (r == 0)
                    lead = CH_NUL;
                else if (r < 6)
                    lead = $urandom_range(1) ? rnd_byte(8'h41, 8'h5A) :
                                               rnd_byte(8'h61, 8'h7A);
                else
                begin
                    lead = rnd_byte(8'h21, 8'h7E);
                    while (chr_digit(lead) || lead inside {[8'h41:8'h5A], [8'h61:8'h7A]})
                        lead = rnd_byte(8'h21, 8'h7E);
                end
                tok_bytes.push_back(lead);
                repeat ($urandom_range(0, 6)) tok_bytes.push_back(rnd_byte(8'h20, 8'h7E));
                tok_bytes.push_back(CH_NUL);
            end
            3:
            begin
                // tagged token: control or high lead byte, tag at the configured offset
                lead = $urandom_range(1) ? rnd_byte(1, 32) : rnd_byte(127, 255);
                r = $urandom_range(9);
                pick = (r < 4) ? cfg_obj_tag : (r < 7) ? cfg_bin_tag : rnd_byte(0, 255);
                if (cfg_tag_off == 8'h00 && is_tag_lead(pick))
                    lead = pick;
                tok_bytes.push_back(lead);
                if (cfg_tag_off > 32 && $urandom_range(3) != 0)
                    repeat ($urandom_range(0, 6)) tok_bytes.push_back(rnd_byte(0, 255));
                else if (cfg_tag_off != 8'h00)
                begin
                    repeat (cfg_tag_off - 1) tok_bytes.push_back(rnd_byte(0, 255));
                    tok_bytes.push_back(pick);
                end
                repeat ($urandom_range(0, 3)) tok_bytes.push_back(rnd_byte(0, 255));
            end
            default:
            begin
                repeat ($urandom_range(1, 8)) tok_bytes.push_back(rnd_byte(0, 255));
            end
        endcase
        // broken token: cut anywhere
        if (cls < 4 && $urandom_range(9) == 0)
        begin
            keep = $urandom_range(1, tok_bytes.size());
            while (tok_bytes.size() > keep)
                void'(tok_bytes.pop_back());
        end
        flush_token();
    endtask

    initial
    begin
        int    target;
        byte_t off;
        byte_t obj;
        byte_t bin;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 14;
        recv_idle = 64;

        // directed tokens at the reset register values
        foreach (INT_SUFFIX[i])
            queue_text({"7", string'(INT_SUFFIX[i])}, 1'b1);
        queue_text("123", 1'b1);
        queue_text("1.5f", 1'b1);
        queue_text("1.5", 1'b1);
        queue_text("1.5d", 1'b1);
        queue_text("1.5x", 1'b1);
        queue_text("12x", 1'b1);
        queue_text("\"a\\\"b\"S", 1'b1);
        queue_text("\"ab\"", 1'b1);
        queue_text("\"a\\", 1'b1);
        queue_text("abc", 1'b1);
        queue_text("", 1'b1);
        queue_text("7bxyz", 1'b1);
        queue_text("9", 1'b0);
        queue_text("\"x", 1'b0);
        tok_bytes = '{8'h05, 8'h33, CH_NUL};
        flush_token();
        tok_bytes = '{8'hFF};
        flush_token();
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // idle pattern: sender light then receiver light, then none
            case (ph / 3)
                0:
                begin
                    send_idle = 14;
                    recv_idle = 64;
                end
                1:
                begin
                    send_idle = 64;
                    recv_idle = 14;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase

            obj = rnd_byte(0, 255);
            bin = rnd_byte(0, 255);
            case (ph)
                0:       {off, obj, bin} = {8'h00, 8'h01, 8'hFF};
                1:       {off, obj, bin} = {8'h03, 8'hFF, 8'h00};
                2:       {off, obj, bin} = {8'hFF, 8'h5A, 8'h5A};
                3:       off = 8'h01;
                4:       {off, obj, bin} = {8'h00, 8'hFF, 8'hFF};
                5:       off = 8'h02;
                6:       off = 8'h07;
                7:       off = rnd_byte(1, 15);
                default: {off, obj, bin} = {8'h01, 8'h00, 8'h01};
            endcase
            reg_write(REG_TAG_OFFSET, off);
            reg_write(REG_OBJECT_TAG, obj);
            reg_write(REG_BINARY_TAG, bin);
            if (ph == 0)
                reg_write(REG_UNUSED, 8'hA5);

            // long tokens: position saturates, tag at the last position
            if (off == 8'hFF)
            begin
                tok_bytes.push_back(8'h80);
                repeat (254) tok_bytes.push_back(rnd_byte(0, 255));
                tok_bytes.push_back(cfg_obj_tag);
                repeat (4) tok_bytes.push_back(rnd_byte(0, 255));
                flush_token();
                tok_bytes.push_back(CH_QUOTE);
                repeat (300) tok_bytes.push_back(8'h61);
                tok_bytes.push_back(CH_QUOTE);
                tok_bytes.push_back(CH_UP_S);
                tok_bytes.push_back(CH_NUL);
                flush_token();
            end

            target = total_pushed + PHASE_BEATS;
            while (total_pushed < target)
                queue_random_token();
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
